// File: src/pmx_pkg.sv
// ----------------------------------------------------------------------------
// pmx_pkg: shared types and constants for the psg/fm resample mixer
// Holds the channel payloads, the controller/datapath command and status
// groups, the divide-by-constant reciprocals and the resampling weight table.
// ----------------------------------------------------------------------------
package pmx_pkg;

    // item kinds
    localparam logic ACT_FM  = 1'b0;
    localparam logic ACT_PSG = 1'b1;

    // resampler shape
    localparam int TAPS      = 5;
    localparam int PHASES    = 5;
    localparam int FM_WEIGHT = 6;

    // reciprocal for a 21 bit magnitude divided by 42
    localparam logic [21:0] DIV42_MULT  = 22'd3195661;
    localparam int          DIV42_SHIFT = 27;
    // reciprocal for an 18 bit magnitude divided by 7
    localparam logic [18:0] DIV7_MULT   = 19'd299594;
    localparam int          DIV7_SHIFT  = 21;

    // input request
    typedef struct packed {
        logic               action;
        logic signed [15:0] fm_left;
        logic signed [15:0] fm_rt;
        logic signed [15:0] psg_value;
    } pmx_in_t;

    // output request
    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic               dropped;
    } pmx_out_t;

    // controller to datapath
    typedef struct packed {
        logic       accept;
        logic       clr_acc;
        logic       rd;
        logic [2:0] tap;
        logic       mul42;
        logic       mix;
        logic       mul7;
        logic       emit;
    } pmx_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic dropped;
        logic go;
        logic out_free;
    } pmx_status_t;

    // weight numerator (over 21) for one tap in one phase; out of range phase acts as phase 0
    function automatic logic [2:0] tap_weight(input logic [2:0] phase, input logic [2:0] tap);
        logic [2:0] ph;
        logic [2:0] w;
        ph = (phase > 3'd4) ? 3'd0 : phase;
        case (tap)
            3'd0:    w = 3'd5 - ph;
            3'd4:    w = ph + 3'd1;
            default: w = 3'd5;
        endcase
        return w;
    endfunction

endpackage

// File: src/psg_fm_resample_mixer.sv
// ----------------------------------------------------------------------------
// psg_fm_resample_mixer: fm stereo and psg mixer with 4.2:1 psg resampling
// Input requests carry either an fm stereo pair or one psg sample. Each kind
// is queued in its own ring queue; once one fm pair and five psg samples are
// queued, a five tap weighted psg value is mixed with the fm pair as
// (6*fm + psg)/7 per channel. A request to a full queue returns a result
// with dropped set and zero samples.
//
// Channels: in_valid/in_stall/in_data and out_valid/out_stall/out_data; a
// request moves when valid is high and stall is low.
// Sequence: a request that makes no output returns to idle after its check; a
// dropped request goes from the check straight to its result load; a mixing
// request loads its result after the five sequential reads of the single psg
// queue port and the two registered reciprocal multiplies.
// One request is worked on at a time; in_stall is low only when idle, so a
// request holds the input until its check is done or its result is loaded.
// A result waits in the output register while out_stall is high; the next
// request is still accepted, and only its own result load waits.
// Reset clears queue pointers, counts, phase and the output valid flag.
// ----------------------------------------------------------------------------
module psg_fm_resample_mixer #(
    parameter int FM_DEPTH  = 64,
    parameter int PSG_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  pmx_pkg::pmx_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output pmx_pkg::pmx_out_t out_data
);
    import pmx_pkg::*;

    pmx_cmd_t    cmd;
    pmx_status_t status;

    // sequencing
    pmx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // queues and arithmetic
    pmx_datapath #(
        .FM_DEPTH  (FM_DEPTH),
        .PSG_DEPTH (PSG_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: src/pmx_ctrl.sv
// ----------------------------------------------------------------------------
// pmx_ctrl: sequencing controller for the resample mixer
// Takes one input request at a time, steps the five tap reads, the two
// reciprocal divides and the output load, waiting for a free output register.
// ----------------------------------------------------------------------------
module pmx_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pmx_pkg::pmx_status_t status,
    output pmx_pkg::pmx_cmd_t    cmd
);
    import pmx_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_MUL42 = 3'd4;
    localparam logic [2:0] S_MIX   = 3'd5;
    localparam logic [2:0] S_MUL7  = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    localparam logic [2:0] LAST_TAP = 3'(TAPS - 1);

    logic [2:0] state_reg, state_next;
    logic [2:0] tap_reg, tap_next;

    // state and tap counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tap_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        tap_next    = tap_reg;
        cmd         = '0;
        cmd.tap     = tap_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.dropped)
                begin
                    state_next = S_EMIT;
                end
                else if (status.go)
                begin
                    cmd.clr_acc = 1'b1;
                    tap_next    = 3'd0;
                    state_next  = S_READ;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.rd   = 1'b1;
                tap_next = tap_reg + 3'd1;
                if (tap_reg == LAST_TAP)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_MUL42;
            end
            S_MUL42:
            begin
                cmd.mul42  = 1'b1;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = S_MUL7;
            end
            S_MUL7:
            begin
                cmd.mul7   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // between requests the queues never hold enough for an output
    a_idle_no_go: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !status.go)
        else $error("queues hold a pending output while idle");

    // a result is never loaded in the cycle right after an accept
    a_no_early_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !cmd.emit)
        else $error("result loaded before the request was checked");

endmodule

// File: src/pmx_datapath.sv
// ----------------------------------------------------------------------------
// pmx_datapath: queues, resampling accumulator and mixer
// Holds the fm and psg ring queues, the five tap weighted sum, the divides by
// 42 and by 7 as reciprocal multiplies, and the output register.
// ----------------------------------------------------------------------------
module pmx_datapath #(
    parameter int FM_DEPTH  = 64,
    parameter int PSG_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pmx_pkg::pmx_in_t     in_data,
    input  pmx_pkg::pmx_cmd_t    cmd,
    output pmx_pkg::pmx_status_t status,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pmx_pkg::pmx_out_t    out_data
);
    import pmx_pkg::*;

    localparam int FHW = $clog2(FM_DEPTH);
    localparam int FCW = $clog2(FM_DEPTH + 1);
    localparam int PHW = $clog2(PSG_DEPTH);
    localparam int PCW = $clog2(PSG_DEPTH + 1);

    localparam logic [FCW:0] FM_D_EXT  = (FCW + 1)'(FM_DEPTH);
    localparam logic [PHW:0] PSG_D_EXT = (PHW + 1)'(PSG_DEPTH);

    // queue memories
    logic signed [15:0] fm_left_mem  [FM_DEPTH];
    logic signed [15:0] fm_rt_mem    [FM_DEPTH];
    logic signed [15:0] psg_mem      [PSG_DEPTH];

    logic [FHW-1:0] fm_head_reg;
    logic [FCW-1:0] fm_count_reg;
    logic [PHW-1:0] psg_head_reg;
    logic [PCW-1:0] psg_count_reg;
    logic [2:0]     phase_reg;
    logic           drop_reg;

    logic signed [15:0] fm_l_rd_reg, fm_r_rd_reg, psg_rd_reg;
    logic               rd_vld_reg;
    logic [2:0]         rd_tap_reg;
    logic signed [20:0] acc_reg;
    logic [42:0]        prod42_reg;
    logic               neg42_reg;
    logic [17:0]        mag_l_reg, mag_r_reg;
    logic               neg_l_reg, neg_r_reg;
    logic [36:0]        prod7_l_reg, prod7_r_reg;
    logic               out_valid_reg;
    pmx_out_t           out_reg;

    // queue fullness and tail addresses
    logic           fm_full, psg_full;
    logic [FCW:0]   fm_tail_sum;
    logic [FCW:0]   fm_tail_wrap;
    logic [FHW-1:0] fm_tail;
    logic [PHW:0]   psg_tail_sum;
    logic [PHW:0]   psg_tail_wrap;
    logic [PHW-1:0] psg_tail;
    logic           fm_wr, psg_wr;

    assign fm_full       = (fm_count_reg == FCW'(FM_DEPTH));
    assign psg_full      = (psg_count_reg == PCW'(PSG_DEPTH));
    assign fm_tail_sum   = (FCW + 1)'(fm_head_reg) + (FCW + 1)'(fm_count_reg);
    assign fm_tail_wrap  = (fm_tail_sum >= FM_D_EXT) ? fm_tail_sum - FM_D_EXT : fm_tail_sum;
    assign fm_tail       = fm_tail_wrap[FHW-1:0];
    assign psg_tail_sum  = (PHW + 1)'(psg_head_reg) + (PHW + 1)'(psg_count_reg);
    assign psg_tail_wrap = (psg_tail_sum >= PSG_D_EXT) ? psg_tail_sum - PSG_D_EXT
                                                       : psg_tail_sum;
    assign psg_tail      = psg_tail_wrap[PHW-1:0];
    assign fm_wr         = cmd.accept && (in_data.action == ACT_FM) && !fm_full;
    assign psg_wr        = cmd.accept && (in_data.action == ACT_PSG) && !psg_full;

    // tap read address
    logic [PHW:0]   psg_rd_sum;
    logic [PHW:0]   psg_rd_wrap;
    logic [PHW-1:0] psg_rd_addr;

    assign psg_rd_sum  = (PHW + 1)'(psg_head_reg) + (PHW + 1)'(cmd.tap);
    assign psg_rd_wrap = (psg_rd_sum >= PSG_D_EXT) ? (psg_rd_sum - PSG_D_EXT) : psg_rd_sum;
    assign psg_rd_addr = psg_rd_wrap[PHW-1:0];

    // fm memories: write at tail, read at head every cycle
    always_ff @(posedge clk)
    begin
        if (fm_wr)
        begin
            fm_left_mem[fm_tail] <= in_data.fm_left;
            fm_rt_mem[fm_tail]   <= in_data.fm_rt;
        end
        fm_l_rd_reg <= fm_left_mem[fm_head_reg];
        fm_r_rd_reg <= fm_rt_mem[fm_head_reg];
    end

    // psg memory: write at tail, read one tap per cycle
    always_ff @(posedge clk)
    begin
        if (psg_wr)
        begin
            psg_mem[psg_tail] <= in_data.psg_value;
        end
        psg_rd_reg <= psg_mem[psg_rd_addr];
    end

    // weighted tap term
    logic [2:0]         w_cur;
    logic signed [20:0] term;

    assign w_cur = tap_weight(phase_reg, rd_tap_reg);
    assign term  = 21'(psg_rd_reg) * 21'(signed'({1'b0, w_cur}));

    // rounding divide by 42, first half
    logic signed [21:0] x42;
    logic [21:0]        x42_abs;

    assign x42     = $signed({acc_reg, 1'b0}) + 22'sd21;
    assign x42_abs = x42[21] ? 22'(-x42) : 22'(x42);

    // psg value and mix sums
    logic [15:0]        q42;
    logic signed [16:0] psg_val;
    logic signed [18:0] mix_l, mix_r;
    logic [18:0]        abs_l, abs_r;

    assign q42     = prod42_reg[DIV42_SHIFT +: 16];
    assign psg_val = neg42_reg ? -$signed({1'b0, q42}) : $signed({1'b0, q42});
    assign mix_l   = 19'(fm_l_rd_reg) * 19'(FM_WEIGHT) + 19'(psg_val);
    assign mix_r   = 19'(fm_r_rd_reg) * 19'(FM_WEIGHT) + 19'(psg_val);
    assign abs_l   = mix_l[18] ? 19'(-mix_l) : 19'(mix_l);
    assign abs_r   = mix_r[18] ? 19'(-mix_r) : 19'(mix_r);

    // divide by 7, final half
    logic [15:0]        q7_l, q7_r;
    logic signed [16:0] res_l, res_r;

    assign q7_l  = prod7_l_reg[DIV7_SHIFT +: 16];
    assign q7_r  = prod7_r_reg[DIV7_SHIFT +: 16];
    assign res_l = neg_l_reg ? -$signed({1'b0, q7_l}) : $signed({1'b0, q7_l});
    assign res_r = neg_r_reg ? -$signed({1'b0, q7_r}) : $signed({1'b0, q7_r});

    // phase advance and head updates
    logic [2:0]     ph_eff;
    logic [2:0]     adv;
    logic [PHW:0]   psg_adv_sum;
    logic [PHW:0]   psg_adv_wrap;
    logic [FHW-1:0] fm_head_inc;

    assign ph_eff       = (phase_reg > 3'd4) ? 3'd0 : phase_reg;
    assign adv          = (ph_eff == 3'(PHASES - 1)) ? 3'd5 : 3'd4;
    assign psg_adv_sum  = (PHW + 1)'(psg_head_reg) + (PHW + 1)'(adv);
    assign psg_adv_wrap = (psg_adv_sum >= PSG_D_EXT) ? psg_adv_sum - PSG_D_EXT : psg_adv_sum;
    assign fm_head_inc  = (fm_head_reg == FHW'(FM_DEPTH - 1)) ? '0 : fm_head_reg + 1'b1;

    // queue control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fm_head_reg   <= '0;
            fm_count_reg  <= '0;
            psg_head_reg  <= '0;
            psg_count_reg <= '0;
            phase_reg     <= 3'd0;
            drop_reg      <= 1'b0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                drop_reg <= (in_data.action == ACT_FM) ? fm_full : psg_full;
            end
            if (fm_wr)
            begin
                fm_count_reg <= fm_count_reg + 1'b1;
            end
            if (psg_wr)
            begin
                psg_count_reg <= psg_count_reg + 1'b1;
            end
            if (cmd.emit && !drop_reg)
            begin
                psg_head_reg  <= psg_adv_wrap[PHW-1:0];
                psg_count_reg <= psg_count_reg - PCW'(adv);
                phase_reg     <= (ph_eff == 3'(PHASES - 1)) ? 3'd0 : ph_eff + 3'd1;
                fm_head_reg   <= fm_head_inc;
                fm_count_reg  <= fm_count_reg - 1'b1;
            end
            rd_vld_reg <= cmd.rd;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // arithmetic pipeline registers
    always_ff @(posedge clk)
    begin
        rd_tap_reg <= cmd.tap;
        if (cmd.clr_acc)
        begin
            acc_reg <= '0;
        end
        else if (rd_vld_reg)
        begin
            acc_reg <= acc_reg + term;
        end
        if (cmd.mul42)
        begin
            prod42_reg <= 43'(x42_abs[20:0]) * 43'(DIV42_MULT);
            neg42_reg  <= x42[21];
        end
        if (cmd.mix)
        begin
            mag_l_reg <= abs_l[17:0];
            mag_r_reg <= abs_r[17:0];
            neg_l_reg <= mix_l[18];
            neg_r_reg <= mix_r[18];
        end
        if (cmd.mul7)
        begin
            prod7_l_reg <= 37'(mag_l_reg) * 37'(DIV7_MULT);
            prod7_r_reg <= 37'(mag_r_reg) * 37'(DIV7_MULT);
        end
        if (cmd.emit)
        begin
            if (drop_reg)
            begin
                out_reg.left_out  <= '0;
                out_reg.right_out <= '0;
                out_reg.dropped   <= 1'b1;
            end
            else
            begin
                out_reg.left_out  <= res_l[15:0];
                out_reg.right_out <= res_r[15:0];
                out_reg.dropped   <= 1'b0;
            end
        end
    end

    assign status.dropped  = drop_reg;
    assign status.go       = (fm_count_reg != '0) && (psg_count_reg >= PCW'(TAPS));
    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;

    a_fm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fm_count_reg <= FCW'(FM_DEPTH))
        else $error("fm queue count past depth");

    a_psg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        psg_count_reg <= PCW'(PSG_DEPTH))
        else $error("psg queue count past depth");

    // a load never overwrites a result that is still held by the receiver
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten while stalled");

    // after a mixed output the queues no longer hold a second one
    a_single_output: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !drop_reg) |=> !status.go)
        else $error("second output pending after an emit");

endmodule
